### design/hsv_to_rgb_pixel_converter_top_macros.svh
// Assertion macros for the HSV to RGB converter.
`ifndef HSV_TO_RGB_PIXEL_CONVERTER_TOP_MACROS_SVH
`define HSV_TO_RGB_PIXEL_CONVERTER_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

`define H2RGB_ASSERT_HOLDS(label, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("h2rgb check failed");

`define H2RGB_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("h2rgb check failed");

`define H2RGB_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("h2rgb check failed");

`else

`define H2RGB_ASSERT_HOLDS(label, cond)

`define H2RGB_ASSERT_IMPL(label, ante, cons)

`define H2RGB_ASSERT_NEXT(label, ante, cons)

`endif

`endif

### design/h2rgb_pkg.sv
package h2rgb_pkg;

   localparam int HUE_W             = 13;
   localparam int CH_W              = 8;
   localparam int HUE_FRAC_BITS_DEF = 4;
   localparam int SECT_DEG          = 60;
   localparam int CH_MAX            = 255;

   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 24;

   // Sector index: x * M >> K, then one correction step
   localparam int SECT_W      = 8;
   localparam int SECT_K      = HUE_W;
   localparam int SECT_M      = (1 << SECT_K) / SECT_DEG;
   localparam int SECT_PROD_W = HUE_W + 8;

   // Ramp over 60: y < 65025 * 60 fits in 22 bits
   localparam int VS_W        = 2 * CH_W;
   localparam int Y_W         = 22;
   localparam int Y_K         = Y_W;
   localparam int Y_M         = (1 << Y_K) / SECT_DEG;
   localparam int Y_PROD_W    = Y_W + 17;

   // Division by 255 over 17-bit numerators
   localparam int DIV_W       = VS_W + 1;
   localparam int DIV_K       = DIV_W;
   localparam int DIV_M       = (1 << DIV_K) / CH_MAX;
   localparam int DIV_PROD_W  = DIV_W + 10;

   localparam logic [2:0] SEC_RY = 3'd0;
   localparam logic [2:0] SEC_YG = 3'd1;
   localparam logic [2:0] SEC_GC = 3'd2;
   localparam logic [2:0] SEC_CB = 3'd3;
   localparam logic [2:0] SEC_BM = 3'd4;
   localparam logic [2:0] SEC_MR = 3'd5;

   typedef logic [CH_W-1:0] chan_type;

   typedef struct packed {
      chan_type blue;
      chan_type green;
      chan_type red;
   } rgb_type;

   function automatic chan_type div255_est(input logic [DIV_W-1:0] x);
      logic [DIV_PROD_W-1:0] prod;
      prod = DIV_PROD_W'(x) * DIV_PROD_W'(DIV_M);
      return CH_W'(prod >> DIV_K);
   endfunction

   function automatic chan_type div255_fix(input logic [DIV_W-1:0] x, input chan_type est);
      logic [DIV_W-1:0] r;
      r = x - DIV_W'(est) * DIV_W'(CH_MAX);
      return (r >= DIV_W'(CH_MAX)) ? chan_type'(est + 1'b1) : est;
   endfunction

endpackage

### design/hsv_to_rgb_pixel_converter_top.sv
// HSV to RGB pixel converter, seven register stages.
// rsp_tvalid rises once the accepted request has passed through every stage register.
// Throughput: one pixel per cycle; a stage holds while it is full and the next one cannot advance.
// A stage takes a new request whenever it is empty, even while a result waits.
// Reset (synchronous) clears the stage valid bits; data registers are not reset.
`include "hsv_to_rgb_pixel_converter_top_macros.svh"

module hsv_to_rgb_pixel_converter_top import h2rgb_pkg::*; #(
   parameter int HUE_FRAC_BITS = HUE_FRAC_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // hue[12:0], saturation[20:13], brightness[28:21]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata   // red[7:0], green[15:8], blue[23:16]
);

   localparam int NST       = 7;
   localparam int PER       = SECT_DEG << HUE_FRAC_BITS;
   localparam int REM_W     = $clog2(PER);
   localparam int RAMP_W    = VS_W + REM_W;
   localparam logic [HUE_W-1:0]  FRAC_MASK = HUE_W'((1 << HUE_FRAC_BITS) - 1);
   localparam logic [RAMP_W-1:0] RAMP_LOW  = RAMP_W'((1 << HUE_FRAC_BITS) - 1);

   logic [NST-1:0] vld_ff;
   logic [NST:0]   adv;

   logic [HUE_W-1:0]       req_hue;
   chan_type               req_sat;
   chan_type               req_val;

   logic [HUE_W-1:0]       s1_hue_ff, s1_hue_in;
   chan_type               s1_v_ff, s1_v_in;
   logic [VS_W-1:0]        s1_g_ff, s1_g_in;
   logic [VS_W-1:0]        s1_a_ff, s1_a_in;
   logic [SECT_W-1:0]      s1_qe_ff, s1_qe_in;
   logic [SECT_PROD_W-1:0] s1_prod;

   logic [HUE_W-1:0]       s2_x;
   logic [HUE_W-1:0]       s2_r0;
   logic                   s2_fix;
   logic [5:0]             s2_r;
   logic [SECT_W-1:0]      s2_q;
   logic [2:0]             s2_sel_ff, s2_sel_in;
   logic [REM_W-1:0]       s2_rem_ff, s2_rem_in;
   logic [VS_W-1:0]        s2_g_ff;
   logic [VS_W-1:0]        s2_a_ff;
   chan_type               s2_v_ff;
   chan_type               s2_loe_ff, s2_loe_in;

   logic [RAMP_W-1:0]      s3_ramp_ff, s3_ramp_in;
   logic [2:0]             s3_sel_ff;
   logic [VS_W-1:0]        s3_a_ff;
   chan_type               s3_v_ff;
   chan_type               s3_lo_ff, s3_lo_in;

   logic [Y_W-1:0]         s4_y_ff, s4_y_in;
   logic [Y_PROD_W-1:0]    s4_prod;
   logic [VS_W-1:0]        s4_te_ff, s4_te_in;
   logic                   s4_nzl_ff, s4_nzl_in;
   logic [2:0]             s4_sel_ff;
   logic [VS_W-1:0]        s4_a_ff;
   chan_type               s4_v_ff;
   chan_type               s4_lo_ff;

   logic [Y_W-1:0]         s5_rr;
   logic                   s5_fix;
   logic [Y_W-1:0]         s5_rem;
   logic [VS_W-1:0]        s5_t_ff, s5_t_in;
   logic                   s5_nz_ff, s5_nz_in;
   logic [2:0]             s5_sel_ff;
   logic [VS_W-1:0]        s5_a_ff;
   chan_type               s5_v_ff;
   chan_type               s5_lo_ff;

   logic [DIV_W-1:0]       s6_upn_ff, s6_upn_in;
   logic [DIV_W-1:0]       s6_dnn_ff, s6_dnn_in;
   chan_type               s6_upe_ff, s6_upe_in;
   chan_type               s6_dne_ff, s6_dne_in;
   logic [2:0]             s6_sel_ff;
   chan_type               s6_v_ff;
   chan_type               s6_lo_ff;

   chan_type               s7_up;
   chan_type               s7_dn;
   rgb_type                s7_rgb_ff, s7_rgb_in;

   assign req_hue = req_tdata[HUE_W-1:0];
   assign req_sat = req_tdata[HUE_W+CH_W-1:HUE_W];
   assign req_val = req_tdata[HUE_W+2*CH_W-1:HUE_W+CH_W];

   // advance a stage when it is empty or the next stage advances
   always_comb begin
      adv[NST] = rsp_tready;
      for (int k = NST - 1; k >= 0; k--) begin
         adv[k] = ~vld_ff[k] | adv[k+1];
      end
   end

   assign req_tready = adv[0];
   assign rsp_tvalid = vld_ff[NST-1];
   assign rsp_tdata  = s7_rgb_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (adv[0]) begin
            vld_ff[0] <= req_tvalid;
         end
         for (int k = 1; k < NST; k++) begin
            if (adv[k]) begin
               vld_ff[k] <= vld_ff[k-1];
            end
         end
      end
   end

   // stage 1: products and sector estimate
   always_comb begin
      s1_hue_in = req_hue;
      s1_v_in   = req_val;
      s1_g_in   = VS_W'(req_val) * VS_W'(req_sat);
      s1_a_in   = VS_W'(req_val) * VS_W'(chan_type'(CH_MAX) - req_sat);
      s1_prod   = SECT_PROD_W'(req_hue >> HUE_FRAC_BITS) * SECT_PROD_W'(SECT_M);
      s1_qe_in  = SECT_W'(s1_prod >> SECT_K);
   end

   // stage 2: sector correction, remainder, floor estimate
   always_comb begin
      s2_x      = s1_hue_ff >> HUE_FRAC_BITS;
      s2_r0     = s2_x - HUE_W'(s1_qe_ff) * HUE_W'(SECT_DEG);
      s2_fix    = s2_r0 >= HUE_W'(SECT_DEG);
      s2_r      = s2_fix ? 6'(s2_r0 - HUE_W'(SECT_DEG)) : 6'(s2_r0);
      s2_q      = s1_qe_ff + SECT_W'(s2_fix);
      s2_sel_in = (s2_q > SECT_W'(SEC_MR)) ? SEC_MR : 3'(s2_q);
      s2_rem_in = REM_W'((HUE_W'(s2_r) << HUE_FRAC_BITS) | (s1_hue_ff & FRAC_MASK));
      s2_loe_in = div255_est(DIV_W'(s1_a_ff));
   end

   // stage 3: ramp numerator, floor level
   always_comb begin
      s3_ramp_in = RAMP_W'(s2_g_ff) * RAMP_W'(s2_rem_ff);
      s3_lo_in   = div255_fix(DIV_W'(s2_a_ff), s2_loe_ff);
   end

   // stage 4: ramp over one sector, estimate
   always_comb begin
      s4_y_in   = Y_W'(s3_ramp_ff >> HUE_FRAC_BITS);
      s4_nzl_in = (s3_ramp_ff & RAMP_LOW) != '0;
      s4_prod   = Y_PROD_W'(s4_y_in) * Y_PROD_W'(Y_M);
      s4_te_in  = VS_W'(s4_prod >> Y_K);
   end

   // stage 5: ramp quotient correction, inexact flag
   always_comb begin
      s5_rr    = s4_y_ff - Y_W'(s4_te_ff) * Y_W'(SECT_DEG);
      s5_fix   = s5_rr >= Y_W'(SECT_DEG);
      s5_rem   = s5_fix ? (s5_rr - Y_W'(SECT_DEG)) : s5_rr;
      s5_t_in  = s4_te_ff + VS_W'(s5_fix);
      s5_nz_in = s4_nzl_ff | (s5_rem != '0);
   end

   // stage 6: rising and falling numerators over 255
   always_comb begin
      s6_upn_in = DIV_W'(s5_a_ff) + DIV_W'(s5_t_ff);
      s6_dnn_in = DIV_W'(s5_v_ff) * DIV_W'(CH_MAX) - DIV_W'(s5_t_ff) - DIV_W'(s5_nz_ff);
      s6_upe_in = div255_est(s6_upn_in);
      s6_dne_in = div255_est(s6_dnn_in);
   end

   // stage 7: final levels and channel selection
   always_comb begin
      s7_up = div255_fix(s6_upn_ff, s6_upe_ff);
      s7_dn = div255_fix(s6_dnn_ff, s6_dne_ff);
      case (s6_sel_ff)
         SEC_RY:  s7_rgb_in = '{red: s6_v_ff,  green: s7_up,   blue: s6_lo_ff};
         SEC_YG:  s7_rgb_in = '{red: s7_dn,    green: s6_v_ff, blue: s6_lo_ff};
         SEC_GC:  s7_rgb_in = '{red: s6_lo_ff, green: s6_v_ff, blue: s7_up};
         SEC_CB:  s7_rgb_in = '{red: s6_lo_ff, green: s7_dn,   blue: s6_v_ff};
         SEC_BM:  s7_rgb_in = '{red: s7_up,    green: s6_lo_ff, blue: s6_v_ff};
         default: s7_rgb_in = '{red: s6_v_ff,  green: s6_lo_ff, blue: s7_dn};
      endcase
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         s1_hue_ff <= s1_hue_in;
         s1_v_ff   <= s1_v_in;
         s1_g_ff   <= s1_g_in;
         s1_a_ff   <= s1_a_in;
         s1_qe_ff  <= s1_qe_in;
      end
      if (adv[1]) begin
         s2_sel_ff <= s2_sel_in;
         s2_rem_ff <= s2_rem_in;
         s2_g_ff   <= s1_g_ff;
         s2_a_ff   <= s1_a_ff;
         s2_v_ff   <= s1_v_ff;
         s2_loe_ff <= s2_loe_in;
      end
      if (adv[2]) begin
         s3_ramp_ff <= s3_ramp_in;
         s3_sel_ff  <= s2_sel_ff;
         s3_a_ff    <= s2_a_ff;
         s3_v_ff    <= s2_v_ff;
         s3_lo_ff   <= s3_lo_in;
      end
      if (adv[3]) begin
         s4_y_ff   <= s4_y_in;
         s4_te_ff  <= s4_te_in;
         s4_nzl_ff <= s4_nzl_in;
         s4_sel_ff <= s3_sel_ff;
         s4_a_ff   <= s3_a_ff;
         s4_v_ff   <= s3_v_ff;
         s4_lo_ff  <= s3_lo_ff;
      end
      if (adv[4]) begin
         s5_t_ff   <= s5_t_in;
         s5_nz_ff  <= s5_nz_in;
         s5_sel_ff <= s4_sel_ff;
         s5_a_ff   <= s4_a_ff;
         s5_v_ff   <= s4_v_ff;
         s5_lo_ff  <= s4_lo_ff;
      end
      if (adv[5]) begin
         s6_upn_ff <= s6_upn_in;
         s6_dnn_ff <= s6_dnn_in;
         s6_upe_ff <= s6_upe_in;
         s6_dne_ff <= s6_dne_in;
         s6_sel_ff <= s5_sel_ff;
         s6_v_ff   <= s5_v_ff;
         s6_lo_ff  <= s5_lo_ff;
      end
      if (adv[6]) begin
         s7_rgb_ff <= s7_rgb_in;
      end
   end

   `H2RGB_ASSERT_IMPL(a_rem_in_sector, vld_ff[1], s2_rem_ff < REM_W'(PER))
   `H2RGB_ASSERT_IMPL(a_floor_below_peak, vld_ff[2], s3_lo_ff <= s3_v_ff)
   `H2RGB_ASSERT_IMPL(a_ramp_rem_small, vld_ff[3], s5_rem < Y_W'(SECT_DEG))
   `H2RGB_ASSERT_IMPL(a_empty_takes, !vld_ff[0], req_tready)
   `H2RGB_ASSERT_NEXT(a_result_kept, rsp_tvalid && !rsp_tready, rsp_tvalid)

endmodule

### dv/hsv_to_rgb_pixel_converter_top_test.sv
module hsv_to_rgb_pixel_converter_top_test;
   import h2rgb_pkg::*;

   localparam int HUE_FRAC    = HUE_FRAC_BITS_DEF;
   localparam int HUE_PERIOD  = SECT_DEG << HUE_FRAC;
   localparam int HUE_TOP     = 6 * HUE_PERIOD - 1;
   localparam int RANDOM_PIX  = 1650;
   localparam int TAIL_PIX    = 150;
   localparam int STALL_LIMIT = 1000;
   localparam int DRAIN_CYC   = 16;
   localparam int REPORT_MAX  = 10;

   typedef struct packed {
      chan_type         brightness;
      chan_type         saturation;
      logic [HUE_W-1:0] hue;
   } pixel_hsv_t;

   logic                  clock;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   pixel_hsv_t hsv_pending[$];
   rgb_type    rgb_expected[$];
   int         rgb_mismatches = 0;
   int         quiet_cycles   = 0;
   logic       req_taken      = 1'b0;
   int         send_gap       = 0;
   int         send_rate      = 0;
   int         recv_stall     = 0;
   int         recv_rate      = 0;
   logic       tail_phase;

   hsv_to_rgb_pixel_converter_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   assign tail_phase = (hsv_pending.size() < TAIL_PIX);

   function automatic rgb_type rgb_from_hsv(input pixel_hsv_t px);
      longint unsigned per, span, sector, rem, v, s;
      longint unsigned floor_num, ramp_num, lo, up, down;
      logic [2:0]      sect;
      rgb_type         c;
      per       = 64'(SECT_DEG) << HUE_FRAC;
      span      = 64'(CH_MAX) * per;
      v         = 64'(px.brightness);
      s         = 64'(px.saturation);
      sector    = 64'(px.hue) / per;
      rem       = 64'(px.hue) - sector * per;
      floor_num = v * (64'(CH_MAX) - s) * per;
      ramp_num  = v * s * rem;
      lo        = floor_num / span;
      up        = (floor_num + ramp_num) / span;
      down      = (v * span - ramp_num) / span;
      sect      = (sector > 64'(SEC_MR)) ? SEC_MR : sector[2:0];
      case (sect)
         SEC_RY: begin c.red = chan_type'(v);    c.green = chan_type'(up);   c.blue = chan_type'(lo);   end
         SEC_YG: begin c.red = chan_type'(down); c.green = chan_type'(v);    c.blue = chan_type'(lo);   end
         SEC_GC: begin c.red = chan_type'(lo);   c.green = chan_type'(v);    c.blue = chan_type'(up);   end
         SEC_CB: begin c.red = chan_type'(lo);   c.green = chan_type'(down); c.blue = chan_type'(v);    end
         SEC_BM: begin c.red = chan_type'(up);   c.green = chan_type'(lo);   c.blue = chan_type'(v);    end
         default: begin c.red = chan_type'(v);   c.green = chan_type'(lo);   c.blue = chan_type'(down); end
      endcase
      return c;
   endfunction

   function automatic chan_type pick_level();
      int sel;
      sel = $urandom_range(0, 19);
      if (sel < 3) return '0;
      if (sel < 6) return chan_type'(CH_MAX);
      return chan_type'($urandom_range(0, CH_MAX));
   endfunction

   function automatic logic [HUE_W-1:0] pick_hue();
      int sel;
      int edge_hue;
      sel = $urandom_range(0, 9);
      if (sel < 7) return HUE_W'($urandom_range(0, HUE_TOP));
      if (sel == 7) begin
         edge_hue = $urandom_range(0, 8) * HUE_PERIOD + $urandom_range(0, 2) - 1;
         if (edge_hue < 0) edge_hue = 0;
         if (edge_hue > (1 << HUE_W) - 1) edge_hue = (1 << HUE_W) - 1;
         return HUE_W'(edge_hue);
      end
      if (sel == 8) return HUE_W'($urandom_range(HUE_TOP + 1, (1 << HUE_W) - 1));
      return HUE_W'($urandom_range(0, (1 << HUE_W) - 1));
   endfunction

   function automatic pixel_hsv_t make_pixel(input int h, input int s, input int v);
      pixel_hsv_t px;
      px.hue        = HUE_W'(h);
      px.saturation = chan_type'(s);
      px.brightness = chan_type'(v);
      return px;
   endfunction

   // drive requests
   always @(negedge clock) begin
      logic       nxt_valid;
      pixel_hsv_t nxt_pix;
      nxt_valid = req_tvalid;
      nxt_pix   = pixel_hsv_t'(req_tdata[$bits(pixel_hsv_t)-1:0]);
      if (reset) begin
         nxt_valid = 1'b0;
      end else if (!req_tvalid || req_taken) begin
         nxt_valid = 1'b0;
         if ($urandom_range(0, 63) == 0) send_rate = $urandom_range(0, 3);
         if (send_gap > 0) begin
            send_gap--;
         end else if (hsv_pending.size() > 0) begin
            if (!tail_phase && send_rate != 0 && $urandom_range(1, 10) <= send_rate) begin
               send_gap = $urandom_range(1, 18) - 1;
            end else begin
               nxt_valid = 1'b1;
               nxt_pix   = hsv_pending.pop_front();
            end
         end
      end
      req_tvalid <= nxt_valid;
      req_tdata  <= REQ_DATA_W'(nxt_pix);
   end

   // drive result backpressure
   always @(negedge clock) begin
      logic nxt_ready;
      nxt_ready = 1'b1;
      if ($urandom_range(0, 63) == 0) recv_rate = $urandom_range(0, 3);
      if (recv_stall > 0) begin
         nxt_ready = 1'b0;
         recv_stall--;
      end else if (!tail_phase && recv_rate != 0 && $urandom_range(1, 10) <= recv_rate) begin
         nxt_ready  = 1'b0;
         recv_stall = $urandom_range(1, 18) - 1;
      end
      rsp_tready <= nxt_ready;
   end

   always @(posedge clock) begin
      rgb_type got;
      rgb_type want;
      logic    moved;
      moved = 1'b0;
      if (reset) begin
         req_taken    <= 1'b0;
         quiet_cycles = 0;
      end else begin
         req_taken <= req_tvalid && req_tready;
         if (req_tvalid && req_tready) begin
            rgb_expected.push_back(rgb_from_hsv(pixel_hsv_t'(req_tdata[$bits(pixel_hsv_t)-1:0])));
            moved = 1'b1;
         end
         if (rsp_tvalid && rsp_tready) begin
            moved = 1'b1;
            got   = rgb_type'(rsp_tdata);
            if (rgb_expected.size() == 0) begin
               rgb_mismatches++;
               if (rgb_mismatches <= REPORT_MAX)
                  $display("unexpected result r=%0d g=%0d b=%0d", got.red, got.green, got.blue);
            end else begin
               want = rgb_expected.pop_front();
               if (got.red != want.red || got.green != want.green || got.blue != want.blue) begin
                  rgb_mismatches++;
                  if (rgb_mismatches <= REPORT_MAX)
                     $display("result mismatch: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                              want.red, want.green, want.blue, got.red, got.green, got.blue);
               end
            end
         end
         if (moved) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("hsv_to_rgb_pixel_converter_top_test: errors");
            $finish;
         end
      end
   end

   initial begin
      hsv_pending.push_back(make_pixel(0, 255, 255));
      hsv_pending.push_back(make_pixel(HUE_PERIOD - 1, 255, 255));
      hsv_pending.push_back(make_pixel(HUE_PERIOD, 255, 255));
      hsv_pending.push_back(make_pixel(2 * HUE_PERIOD, 200, 255));
      hsv_pending.push_back(make_pixel(3 * HUE_PERIOD, 255, 128));
      hsv_pending.push_back(make_pixel(4 * HUE_PERIOD, 100, 200));
      hsv_pending.push_back(make_pixel(5 * HUE_PERIOD, 255, 255));
      hsv_pending.push_back(make_pixel(HUE_TOP, 255, 255));
      hsv_pending.push_back(make_pixel(HUE_TOP + 1, 255, 255));
      hsv_pending.push_back(make_pixel(7 * HUE_PERIOD - 1, 255, 255));
      hsv_pending.push_back(make_pixel((1 << HUE_W) - 1, 255, 255));
      hsv_pending.push_back(make_pixel(7000, 128, 77));
      hsv_pending.push_back(make_pixel(1234, 0, 255));
      hsv_pending.push_back(make_pixel(3000, 0, 0));
      hsv_pending.push_back(make_pixel(4000, 255, 0));
      hsv_pending.push_back(make_pixel(HUE_PERIOD / 2, 255, 1));
      hsv_pending.push_back(make_pixel(2400, 1, 255));
      hsv_pending.push_back(make_pixel(5000, 254, 254));
      hsv_pending.push_back(make_pixel(100, 128, 128));
      hsv_pending.push_back(make_pixel(4321, 77, 33));
      hsv_pending.push_back(make_pixel(3500, 170, 85));
      hsv_pending.push_back(make_pixel(1700, 85, 170));
      for (int i = 0; i < RANDOM_PIX; i++) begin
         pixel_hsv_t px;
         px.hue        = pick_hue();
         px.saturation = pick_level();
         px.brightness = pick_level();
         hsv_pending.push_back(px);
      end

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (hsv_pending.size() != 0 || req_tvalid || rgb_expected.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYC) @(negedge clock);

      if (rgb_mismatches == 0 && rgb_expected.size() == 0) begin
         $display("hsv_to_rgb_pixel_converter_top_test: clean");
      end else begin
         $display("hsv_to_rgb_pixel_converter_top_test: errors");
      end
      $finish;
   end
endmodule
